/* design/mtok_pkg.sv */
// Shared types and constants of the expression tokenizer.
package mtok_pkg;

  localparam int unsigned MAX_NUMBER_LEN = 128;
  localparam int unsigned MAX_EXPR_LEN = 65535;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    KIND_END     = 4'd0,
    KIND_PLUS    = 4'd1,
    KIND_MINUS   = 4'd2,
    KIND_STAR    = 4'd3,
    KIND_SLASH   = 4'd4,
    KIND_CARET   = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_LBRACE  = 4'd8,
    KIND_RBRACE  = 4'd9,
    KIND_COMMAND = 4'd10,
    KIND_NUMBER  = 4'd11,
    KIND_IDENT   = 4'd12,
    KIND_INVALID = 4'd13
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_BACKSLASH = 2'd1,
    ERR_TOO_LONG  = 2'd2,
    ERR_CHAR      = 2'd3
  } err_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    err_kind_t   err;
    logic [15:0] start;
    logic [15:0] len;
  } token_t;

  typedef struct packed {
    token_t first;
    token_t second;
    logic   has_second;
  } bundle_t;

endpackage

/* design/mtok_front.sv */
// Scanner front end: classifies each byte and builds the tokens it completes.
module mtok_front import mtok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ch,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       queue_full,
  output logic       push,
  output bundle_t    push_data
);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_DOT   = 3'd1,
    M_BSL   = 3'd2,
    M_INT   = 3'd3,
    M_FRAC  = 3'd4,
    M_IDENT = 3'd5,
    M_CMD   = 3'd6
  } mode_t;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_UND = 8'h5F;
  localparam logic [15:0] NUM_LIMIT = 16'(MAX_NUMBER_LEN);
  localparam logic [15:0] POS_LIMIT = 16'(MAX_EXPR_LEN);

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_word_start(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UND);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic tok_kind_t single_kind(input logic [7:0] c);
    case (c)
      8'h2B: return KIND_PLUS;
      8'h2D: return KIND_MINUS;
      8'h2A: return KIND_STAR;
      8'h2F: return KIND_SLASH;
      8'h5E: return KIND_CARET;
      8'h28: return KIND_LPAREN;
      8'h29: return KIND_RPAREN;
      8'h7B: return KIND_LBRACE;
      8'h7D: return KIND_RBRACE;
      default: return KIND_END;
    endcase
  endfunction

  function automatic token_t mk_tok(input tok_kind_t k, input err_kind_t e,
                                    input logic [15:0] s, input logic [15:0] l);
    token_t t;
    t.kind = k;
    t.err = e;
    t.start = s;
    t.len = l;
    return t;
  endfunction

  mode_t       mode, mode_next;
  logic [15:0] byte_position, byte_position_next;
  logic [15:0] lexeme_start, lexeme_start_next;
  logic        va, vb, done, is_end, accept;
  token_t      tok_a, tok_b, num_tok;
  tok_kind_t   sk;
  logic [15:0] lex_len;

  assign in_ready = !queue_full;
  assign accept = in_valid && in_ready;
  assign lex_len = byte_position - lexeme_start;
  assign sk = single_kind(ch);
  assign num_tok = (lex_len >= NUM_LIMIT) ?
                   mk_tok(KIND_INVALID, ERR_TOO_LONG, lexeme_start, lex_len) :
                   mk_tok(KIND_NUMBER, ERR_NONE, lexeme_start, lex_len);

  always_comb begin
    va = 1'b0;
    vb = 1'b0;
    done = 1'b0;
    is_end = 1'b0;
    tok_a = '0;
    tok_b = '0;
    mode_next = mode;
    lexeme_start_next = lexeme_start;
    case (mode)
      M_DOT: begin
        if (is_digit(ch)) begin
          mode_next = M_FRAC;
          done = 1'b1;
        end else begin
          va = 1'b1;
          tok_a = mk_tok(KIND_INVALID, ERR_CHAR, lexeme_start, 16'd1);
        end
      end
      M_BSL: begin
        if (is_word_start(ch)) begin
          mode_next = M_CMD;
          lexeme_start_next = byte_position;
          done = 1'b1;
        end else begin
          va = 1'b1;
          tok_a = mk_tok(KIND_INVALID, ERR_BACKSLASH, lexeme_start, 16'd1);
        end
      end
      M_INT: begin
        if (is_digit(ch)) begin
          done = 1'b1;
        end else if (ch == CH_DOT) begin
          mode_next = M_FRAC;
          done = 1'b1;
        end else begin
          va = 1'b1;
          tok_a = num_tok;
        end
      end
      M_FRAC: begin
        if (is_digit(ch)) begin
          done = 1'b1;
        end else begin
          va = 1'b1;
          tok_a = num_tok;
        end
      end
      M_IDENT, M_CMD: begin
        if (is_word_start(ch) || is_digit(ch)) begin
          done = 1'b1;
        end else begin
          va = 1'b1;
          tok_a = mk_tok((mode == M_IDENT) ? KIND_IDENT : KIND_COMMAND, ERR_NONE,
                         lexeme_start, lex_len);
        end
      end
      default: ;
    endcase

    if (!done) begin
      mode_next = M_IDLE;
      if (ch == 8'h00) begin
        vb = 1'b1;
        is_end = 1'b1;
        tok_b = mk_tok(KIND_END, ERR_NONE, byte_position, 16'd0);
        lexeme_start_next = '0;
      end else if (is_blank(ch)) begin
        vb = 1'b0;
      end else if (sk != KIND_END) begin
        vb = 1'b1;
        tok_b = mk_tok(sk, ERR_NONE, byte_position, 16'd1);
      end else if (ch == CH_BSL) begin
        mode_next = M_BSL;
        lexeme_start_next = byte_position;
      end else if (is_digit(ch)) begin
        mode_next = M_INT;
        lexeme_start_next = byte_position;
      end else if (ch == CH_DOT) begin
        mode_next = M_DOT;
        lexeme_start_next = byte_position;
      end else if (is_word_start(ch)) begin
        mode_next = M_IDENT;
        lexeme_start_next = byte_position;
      end else begin
        vb = 1'b1;
        tok_b = mk_tok(KIND_INVALID, ERR_CHAR, byte_position, 16'd1);
      end
    end

    if (is_end) begin
      byte_position_next = '0;
    end else if (byte_position < POS_LIMIT) begin
      byte_position_next = byte_position + 16'd1;
    end else begin
      byte_position_next = byte_position;
    end
  end

  assign push = accept && (va || vb);
  assign push_data.first = va ? tok_a : tok_b;
  assign push_data.second = tok_b;
  assign push_data.has_second = va && vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      byte_position <= '0;
      lexeme_start <= '0;
    end else if (accept) begin
      mode <= mode_next;
      byte_position <= byte_position_next;
      lexeme_start <= lexeme_start_next;
    end
  end

endmodule

/* design/mtok_queue.sv */
// Short token queue between the scanner and the output stage.
module mtok_queue import mtok_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    empty,
  output bundle_t head
);

  bundle_t               mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;
  logic                  do_push, do_pop;

  assign full = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/mtok_back.sv */
// Output stage: splits queued token pairs and presents one token per item.
module mtok_back import mtok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  bundle_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  tok_kind,
  output logic [1:0]  err_kind,
  output logic [15:0] tok_start,
  output logic [15:0] tok_len,
  output logic        primary_start,
  output logic        last_of_run
);

  token_t out_tok, pend_tok;
  logic   out_last, pend_valid, load;

  assign load = !out_valid || out_ready;
  assign pop = load && !pend_valid && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else if (load) begin
      if (pend_valid) begin
        out_valid <= 1'b1;
        pend_valid <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        pend_valid <= head.has_second;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_valid) begin
        out_tok <= pend_tok;
        out_last <= 1'b1;
      end else if (!empty) begin
        out_tok <= head.first;
        out_last <= !head.has_second;
        pend_tok <= head.second;
      end
    end
  end

  assign tok_kind = out_tok.kind;
  assign err_kind = out_tok.err;
  assign tok_start = out_tok.start;
  assign tok_len = out_tok.len;
  assign last_of_run = out_last;
  assign primary_start = (out_tok.kind == KIND_NUMBER) || (out_tok.kind == KIND_IDENT) ||
                         (out_tok.kind == KIND_COMMAND) || (out_tok.kind == KIND_LPAREN) ||
                         (out_tok.kind == KIND_LBRACE);

endmodule

/* design/math_expression_tokenizer_top.sv */
// Top level of the streaming expression tokenizer.
// The tokenizer takes one source byte per cycle whenever its four-entry token
// queue has room, and the output register delivers one token per cycle while
// out_ready is high. A byte that closes an open lexeme and also forms a token
// of its own yields two tokens, which leave the output one after the other;
// bytes inside a lexeme and whitespace yield none. A completed token goes to the
// queue when its byte is taken, then into the output register; the second token
// of a pair waits in a pending register until the first is accepted. A zero
// byte emits the end token and clears the scanner for the next expression.
module math_expression_tokenizer_top import mtok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  tok_kind,
  output logic [1:0]  err_kind,
  output logic [15:0] tok_start,
  output logic [15:0] tok_len,
  output logic        primary_start,
  output logic        last_of_run
);

  logic    push, full, pop, empty;
  bundle_t push_data, head;

  mtok_front u_front (
    .clk        (clk),
    .rst        (rst),
    .ch         (ch),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .queue_full (full),
    .push       (push),
    .push_data  (push_data)
  );

  mtok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  mtok_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .tok_kind      (tok_kind),
    .err_kind      (err_kind),
    .tok_start     (tok_start),
    .tok_len       (tok_len),
    .primary_start (primary_start),
    .last_of_run   (last_of_run)
  );

endmodule

/* design/mtok_checker.sv */
// Port-level checks for the expression tokenizer, bound to the top level.
module mtok_checker import mtok_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  tok_kind,
  input logic [1:0]  err_kind,
  input logic [15:0] tok_start,
  input logic [15:0] tok_len,
  input logic        primary_start,
  input logic        last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tok_kind) && $stable(tok_start)
      && $stable(tok_len) && $stable(last_of_run))
    else $error("Output item changed while stalled.");

  a_primary: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> primary_start == ((tok_kind == KIND_NUMBER) || (tok_kind == KIND_IDENT)
      || (tok_kind == KIND_COMMAND) || (tok_kind == KIND_LPAREN)
      || (tok_kind == KIND_LBRACE)))
    else $error("Primary-start flag disagrees with token kind.");

  a_err_only_invalid: assert property (@(posedge clk) disable iff (rst)
    out_valid && (tok_kind != KIND_INVALID) |-> err_kind == ERR_NONE)
    else $error("Error code on a valid token.");

  a_end_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && (tok_kind == KIND_END) |-> (tok_len == 16'd0) && last_of_run)
    else $error("End token with nonzero length or not last of its run.");

  a_single_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (tok_kind != KIND_END) && (tok_kind != KIND_COMMAND)
      && (tok_kind != KIND_NUMBER) && (tok_kind != KIND_IDENT)
      && (tok_kind != KIND_INVALID) |-> tok_len == 16'd1)
    else $error("Single-symbol token with length other than one.");

endmodule

bind math_expression_tokenizer_top mtok_checker u_mtok_checker (.*);
